>>> src/acoustic_tensor_inverse_unit_defines.svh
// Assertion macros for the acoustic tensor inverse unit.
// Included by the port-level checker; no other dependencies.
`ifndef ACOUSTIC_TENSOR_INVERSE_UNIT_DEFINES_SVH
`define ACOUSTIC_TENSOR_INVERSE_UNIT_DEFINES_SVH

// next-cycle implication, off during reset
`define ATI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live during reset
`define ATI_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/atinv_pkg.sv
// Shared constants, types and index helpers of the acoustic tensor inverse unit.
// No dependencies; used by every RTL module.
package atinv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 18;
  localparam int NUM_COEF   = 81;
  localparam int COEF_IDX_W = 7;
  localparam int NUM_PAIR   = 6;
  localparam int NUM_ELEM   = 9;

  localparam int QBITS = 33;
  localparam int TW    = 100;
  localparam int DW    = 98;
  localparam int DIVW  = (2 * FRAC_BITS + 66 > 98) ? 2 * FRAC_BITS + 66 : 98;
  localparam int CW    = DIVW + QBITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam int TENSOR_LAT = 8;
  localparam int LANE_LAT   = QBITS + 2;
  localparam int PIPE_LAT   = TENSOR_LAT + LANE_LAT;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef logic signed [31:0] q32_t;

  typedef struct packed {
    q32_t                  wave_x;
    q32_t                  wave_y;
    q32_t                  wave_z;
    logic [INDEX_BITS-1:0] index;
  } point_t;

  typedef logic [NUM_COEF-1:0][31:0] coef_tab_t;

  function automatic int pair_k(int p);
    int k;
    case (p)
      0, 3, 4: k = 0;
      1, 5:    k = 1;
      default: k = 2;
    endcase
    return k;
  endfunction

  function automatic int pair_l(int p);
    int l;
    case (p)
      0:       l = 0;
      1, 3:    l = 1;
      default: l = 2;
    endcase
    return l;
  endfunction

  function automatic logic [COEF_IDX_W-1:0] coef_at(int r, int k, int l, int c);
    return COEF_IDX_W'(27 * r + 9 * k + 3 * l + c);
  endfunction

endpackage

>>> src/atinv_fifo.sv
// Point queue between the intake front and the arithmetic back.
// Depends on atinv_pkg.
module atinv_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atinv_pkg::point_t din,
  output logic              full,
  output logic              not_empty,
  input  logic              pop,
  output atinv_pkg::point_t dout
);

  atinv_pkg::point_t                  mem_r [atinv_pkg::FIFO_DEPTH];
  logic [atinv_pkg::FIFO_AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [atinv_pkg::FIFO_CW-1:0]      cnt_r, cnt_nxt;

  assign full      = (cnt_r == atinv_pkg::FIFO_CW'(atinv_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + atinv_pkg::FIFO_CW'(push) - atinv_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

>>> src/atinv_front.sv
// Intake front: classifies items, holds the stiffness table, queues points.
// Depends on atinv_pkg.
module atinv_front (
  input  logic                                 clk,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [atinv_pkg::COEF_IDX_W-1:0]     in_coef_index,
  input  logic signed [31:0]                   in_coef_value,
  input  logic signed [31:0]                   in_wave_x,
  input  logic signed [31:0]                   in_wave_y,
  input  logic signed [31:0]                   in_wave_z,
  input  logic [atinv_pkg::INDEX_BITS-1:0]     in_point_index,
  output logic                                 push,
  output atinv_pkg::point_t                    push_pt,
  input  logic                                 fifo_full,
  input  logic                                 fifo_not_empty,
  input  logic                                 p1_busy,
  output atinv_pkg::coef_tab_t                 tab
);

  logic [31:0] tab_r [atinv_pkg::NUM_COEF];
  logic        accept;
  logic        wr;

  // hold loads until no queued or first-stage point still has to read the table
  assign in_stall = (in_kind == atinv_pkg::KIND_POINT) ? fifo_full
                                                       : (fifo_not_empty || p1_busy);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_kind == atinv_pkg::KIND_POINT);
  assign wr       = accept && (in_kind == atinv_pkg::KIND_LOAD)
                    && (in_coef_index < atinv_pkg::COEF_IDX_W'(atinv_pkg::NUM_COEF));

  assign push_pt.wave_x = in_wave_x;
  assign push_pt.wave_y = in_wave_y;
  assign push_pt.wave_z = in_wave_z;
  assign push_pt.index  = in_point_index;

  always_comb begin
    for (int i = 0; i < atinv_pkg::NUM_COEF; i++) begin
      tab[i] = tab_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      tab_r[in_coef_index] <= in_coef_value;
    end
  end

endmodule

>>> src/atinv_div_lane.sv
// One output lane: adjugate/determinant quotient with rounding and saturation.
// Restoring divider, one quotient bit per stage. Depends on atinv_pkg.
module atinv_div_lane (
  input  logic                           clk,
  input  logic                           adv,
  input  logic signed [63:0]             adj_i,
  input  logic signed [atinv_pkg::DW-1:0] det_i,
  output logic [31:0]                    g_o,
  output logic                           sing_o
);

  localparam int QB = atinv_pkg::QBITS;
  localparam int FB = atinv_pkg::FRAC_BITS;

  logic [atinv_pkg::DIVW-1:0] rem_r [QB+1];
  logic [atinv_pkg::DIVW-1:0] rem_nxt [QB+1];
  logic [atinv_pkg::DIVW-1:0] den_r [QB+1];
  logic [QB-1:0]              q_r [QB+1];
  logic [QB-1:0]              q_nxt [QB+1];
  logic                       neg_r [QB+1];
  logic                       ovf_r [QB+1];
  logic                       sing_r [QB+1];
  logic [31:0]                sval_r [QB+1];

  logic [63:0]                mag_a;
  logic [atinv_pkg::DW-1:0]   mag_d;
  logic [atinv_pkg::DIVW-1:0] num0, den0;
  logic                       ovf0;
  logic signed [64:0]         rnd, sh;
  logic [31:0]                sval0;
  logic [31:0]                g_nxt;
  logic [QB-1:0]              qf;
  logic [QB-1:0]              neg_q;

  always_comb begin
    mag_a = adj_i[63] ? 64'(-adj_i) : 64'(adj_i);
    mag_d = det_i[atinv_pkg::DW-1] ? atinv_pkg::DW'(-det_i) : atinv_pkg::DW'(det_i);
    num0  = (atinv_pkg::DIVW'(mag_a) << (2 * FB + 1)) + atinv_pkg::DIVW'(mag_d);
    den0  = atinv_pkg::DIVW'(mag_d) << 1;
    ovf0  = atinv_pkg::CW'(num0) >= (atinv_pkg::CW'(den0) << QB);
    rnd   = 65'(adj_i) + (65'(1) << (FB - 1));
    sh    = rnd >>> FB;
    if ((&sh[64:31]) || !(|sh[64:31])) begin
      sval0 = sh[31:0];
    end else begin
      sval0 = sh[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    logic [atinv_pkg::CW-1:0] trial;
    logic [atinv_pkg::CW-1:0] sub;
    rem_nxt[0] = num0;
    q_nxt[0]   = '0;
    for (int s = 1; s <= QB; s++) begin
      trial = atinv_pkg::CW'(rem_r[s-1]);
      sub   = atinv_pkg::CW'(den_r[s-1]) << (QB - s);
      if (trial >= sub) begin
        rem_nxt[s] = atinv_pkg::DIVW'(trial - sub);
        q_nxt[s]   = q_r[s-1] | (QB'(1) << (QB - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
    end
  end

  always_comb begin
    qf    = q_r[QB];
    neg_q = -qf;
    if (sing_r[QB]) begin
      g_nxt = sval_r[QB];
    end else if (ovf_r[QB]) begin
      g_nxt = neg_r[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_r[QB]) begin
      g_nxt = (qf > QB'(32'h8000_0000)) ? 32'h8000_0000 : neg_q[31:0];
    end else begin
      g_nxt = (qf > QB'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= rem_nxt[0];
      den_r[0]  <= den0;
      q_r[0]    <= q_nxt[0];
      neg_r[0]  <= adj_i[63] ^ det_i[atinv_pkg::DW-1];
      ovf_r[0]  <= ovf0;
      sing_r[0] <= (det_i == '0);
      sval_r[0] <= sval0;
      for (int s = 1; s <= QB; s++) begin
        rem_r[s]  <= rem_nxt[s];
        den_r[s]  <= den_r[s-1];
        q_r[s]    <= q_nxt[s];
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        sing_r[s] <= sing_r[s-1];
        sval_r[s] <= sval_r[s-1];
      end
      g_o    <= g_nxt;
      sing_o <= sing_r[QB];
    end
  end

endmodule

>>> src/atinv_back.sv
// Arithmetic back: tensor, adjugate and determinant stages, then nine divide lanes.
// Depends on atinv_pkg and atinv_div_lane.
module atinv_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pt_valid,
  input  atinv_pkg::point_t                pt,
  output logic                             pop,
  input  atinv_pkg::coef_tab_t             tab,
  output logic                             p1_busy,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [atinv_pkg::INDEX_BITS-1:0] out_index,
  output logic [atinv_pkg::NUM_ELEM-1:0][31:0] g,
  output logic                             singular
);

  localparam int NP = atinv_pkg::NUM_PAIR;
  localparam int NE = atinv_pkg::NUM_ELEM;
  localparam int PL = atinv_pkg::PIPE_LAT;
  localparam int TW = atinv_pkg::TW;
  localparam int DW = atinv_pkg::DW;
  localparam int FB = atinv_pkg::FRAC_BITS;

  function automatic int ai(int row, int col);
    return 3 * (row % 3) + (col % 3);
  endfunction

  logic                             adv;
  logic [PL-1:0]                    v_r, v_nxt;
  logic [atinv_pkg::INDEX_BITS-1:0] idx_r [PL];

  logic signed [63:0] nn_r [NP];
  logic signed [63:0] nn_nxt [NP];
  logic signed [64:0] ph_r [NE][NP];
  logic signed [64:0] ph_nxt [NE][NP];
  logic signed [65:0] pl_r [NE][NP];
  logic signed [65:0] pl_nxt [NE][NP];
  logic signed [67:0] sumh_r [NE];
  logic signed [67:0] sumh_nxt [NE];
  logic signed [68:0] suml_r [NE];
  logic signed [68:0] suml_nxt [NE];
  logic signed [31:0] a_r [NE];
  logic signed [31:0] a_nxt [NE];
  logic signed [63:0] pa_r [NE];
  logic signed [63:0] pb_r [NE];
  logic signed [63:0] pa_nxt [NE];
  logic signed [63:0] pb_nxt [NE];
  logic signed [31:0] a05_r [3];
  logic signed [31:0] a06_r [3];
  logic signed [63:0] adj6_r [NE];
  logic signed [63:0] adj7_r [NE];
  logic signed [63:0] adj8_r [NE];
  logic signed [63:0] dh_r [3];
  logic signed [64:0] dl_r [3];
  logic signed [63:0] dh_nxt [3];
  logic signed [64:0] dl_nxt [3];
  logic signed [DW-1:0] det_r, det_nxt;
  logic signed [31:0] w [3];

  assign adv       = !(v_r[PL-1] && out_stall);
  assign pop       = adv && pt_valid;
  assign p1_busy   = v_r[0];
  assign out_valid = v_r[PL-1];
  assign out_index = idx_r[PL-1];
  assign v_nxt     = {v_r[PL-2:0], pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    w[0] = pt.wave_x;
    w[1] = pt.wave_y;
    w[2] = pt.wave_z;
    for (int p = 0; p < NP; p++) begin
      nn_nxt[p] = 64'(w[atinv_pkg::pair_k(p)]) * 64'(w[atinv_pkg::pair_l(p)]);
    end
  end

  always_comb begin
    logic signed [32:0] cs;
    int k, l;
    for (int e = 0; e < NE; e++) begin
      for (int p = 0; p < NP; p++) begin
        k  = atinv_pkg::pair_k(p);
        l  = atinv_pkg::pair_l(p);
        cs = 33'($signed(tab[atinv_pkg::coef_at(e / 3, k, l, e % 3)]));
        if (k != l) begin
          cs = cs + 33'($signed(tab[atinv_pkg::coef_at(e / 3, l, k, e % 3)]));
        end
        ph_nxt[e][p] = cs * $signed(nn_r[p][63:32]);
        pl_nxt[e][p] = cs * $signed({1'b0, nn_r[p][31:0]});
      end
    end
  end

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      sumh_nxt[e] = '0;
      suml_nxt[e] = '0;
      for (int p = 0; p < NP; p++) begin
        sumh_nxt[e] = sumh_nxt[e] + 68'(ph_r[e][p]);
        suml_nxt[e] = suml_nxt[e] + 69'(pl_r[e][p]);
      end
    end
  end

  always_comb begin
    logic signed [TW-1:0] acc;
    logic signed [TW-1:0] sh;
    for (int e = 0; e < NE; e++) begin
      acc = (TW'(sumh_r[e]) <<< 32) + TW'(suml_r[e]) + (TW'(1) << (2 * FB - 1));
      sh  = acc >>> (2 * FB);
      if ((&sh[TW-1:31]) || !(|sh[TW-1:31])) begin
        a_nxt[e] = sh[31:0];
      end else begin
        a_nxt[e] = sh[TW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_nxt[3*r+c] = 64'(a_r[ai(c + 1, r + 1)]) * 64'(a_r[ai(c + 2, r + 2)]);
        pb_nxt[3*r+c] = 64'(a_r[ai(c + 1, r + 2)]) * 64'(a_r[ai(c + 2, r + 1)]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dh_nxt[c] = 64'(a06_r[c]) * 64'($signed(adj6_r[3*c][63:32]));
      dl_nxt[c] = 65'(a06_r[c]) * $signed({1'b0, adj6_r[3*c][31:0]});
    end
    det_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      det_nxt = det_nxt + (DW'(dh_r[c]) <<< 32) + DW'(dl_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[0] <= pt.index;
      for (int i = 1; i < PL; i++) begin
        idx_r[i] <= idx_r[i-1];
      end
      nn_r     <= nn_nxt;
      ph_r     <= ph_nxt;
      pl_r     <= pl_nxt;
      sumh_r   <= sumh_nxt;
      suml_r   <= suml_nxt;
      a_r      <= a_nxt;
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      for (int c = 0; c < 3; c++) begin
        a05_r[c] <= a_r[c];
        a06_r[c] <= a05_r[c];
      end
      for (int e = 0; e < NE; e++) begin
        adj6_r[e] <= pa_r[e] - pb_r[e];
        adj7_r[e] <= adj6_r[e];
        adj8_r[e] <= adj7_r[e];
      end
      dh_r     <= dh_nxt;
      dl_r     <= dl_nxt;
      det_r    <= det_nxt;
    end
  end

  for (genvar e = 0; e < NE; e++) begin : g_lane
    if (e == 0) begin : g_first
      atinv_div_lane u_lane (
        .clk    (clk),
        .adv    (adv),
        .adj_i  (adj8_r[e]),
        .det_i  (det_r),
        .g_o    (g[e]),
        .sing_o (singular)
      );
    end else begin : g_rest
      atinv_div_lane u_lane (
        .clk    (clk),
        .adv    (adv),
        .adj_i  (adj8_r[e]),
        .det_i  (det_r),
        .g_o    (g[e]),
        .sing_o ()
      );
    end
  end

endmodule

>>> src/acoustic_tensor_inverse_unit.sv
// Acoustic tensor inverse unit, top level.
// Depends on atinv_pkg, atinv_front, atinv_fifo and atinv_back.
//
// Load items (kind 0) write one stiffness coefficient C[i][k][l][j]; indexes above 80
// are dropped. Point items (kind 1) produce one result each: the inverse of the 3x3
// acoustic tensor for the wave vector, in Q16.16 with saturation, or the adjugate
// with singular set when the determinant is zero. Points are taken one per cycle while
// the point queue is not full, and each result passes through the point queue, the
// tensor, adjugate and determinant arithmetic, and a divide lane whose restoring
// divider retires one quotient bit per stage. Every stage advances together and
// freezes while a result is stalled; the four-entry queue keeps taking points
// meanwhile. A load waits until no queued or first-stage point still has to read
// the table, so a load right after a point waits while that point is queued and in the
// first stage, and longer while more points are queued or the result side stalls.
module acoustic_tensor_inverse_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [atinv_pkg::COEF_IDX_W-1:0] in_coef_index,
  input  logic signed [31:0]               in_coef_value,
  input  logic signed [31:0]               in_wave_x,
  input  logic signed [31:0]               in_wave_y,
  input  logic signed [31:0]               in_wave_z,
  input  logic [atinv_pkg::INDEX_BITS-1:0] in_point_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [atinv_pkg::INDEX_BITS-1:0] out_index,
  output logic signed [31:0]               out_g11,
  output logic signed [31:0]               out_g12,
  output logic signed [31:0]               out_g13,
  output logic signed [31:0]               out_g21,
  output logic signed [31:0]               out_g22,
  output logic signed [31:0]               out_g23,
  output logic signed [31:0]               out_g31,
  output logic signed [31:0]               out_g32,
  output logic signed [31:0]               out_g33,
  output logic                             out_singular
);

  logic                                         push;
  atinv_pkg::point_t                            push_pt;
  logic                                         fifo_full;
  logic                                         fifo_not_empty;
  logic                                         pop;
  atinv_pkg::point_t                            head_pt;
  logic                                         p1_busy;
  atinv_pkg::coef_tab_t                         tab;
  logic [atinv_pkg::NUM_ELEM-1:0][31:0]         g;

  atinv_front u_front (
    .clk            (clk),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_wave_x      (in_wave_x),
    .in_wave_y      (in_wave_y),
    .in_wave_z      (in_wave_z),
    .in_point_index (in_point_index),
    .push           (push),
    .push_pt        (push_pt),
    .fifo_full      (fifo_full),
    .fifo_not_empty (fifo_not_empty),
    .p1_busy        (p1_busy),
    .tab            (tab)
  );

  atinv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (push_pt),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .pop       (pop),
    .dout      (head_pt)
  );

  atinv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (fifo_not_empty),
    .pt        (head_pt),
    .pop       (pop),
    .tab       (tab),
    .p1_busy   (p1_busy),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_index (out_index),
    .g         (g),
    .singular  (out_singular)
  );

  assign out_g11 = g[0];
  assign out_g12 = g[1];
  assign out_g13 = g[2];
  assign out_g21 = g[3];
  assign out_g22 = g[4];
  assign out_g23 = g[5];
  assign out_g31 = g[6];
  assign out_g32 = g[7];
  assign out_g33 = g[8];

endmodule

>>> src/atinv_checker.sv
// Port-level checker for the acoustic tensor inverse unit, bound to the top level.
// Depends on atinv_pkg and acoustic_tensor_inverse_unit_defines.svh.
`include "acoustic_tensor_inverse_unit_defines.svh"

module atinv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_kind,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [atinv_pkg::INDEX_BITS-1:0] out_index
);

  `ATI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_index), "stalled result transaction dropped or changed")

  `ATI_ASSERT_NEXT_NORST(a_reset_idle, clk, !rst_n, !out_valid, "result valid right after reset")

  `ATI_ASSERT_NEXT(a_load_after_point, clk, rst_n, in_valid && !in_stall && in_kind == atinv_pkg::KIND_POINT, !(in_valid && !in_stall && in_kind == atinv_pkg::KIND_LOAD), "load taken while a point still reads the table")

endmodule

bind acoustic_tensor_inverse_unit atinv_checker u_atinv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_index (out_index)
);

>>> tb/tb_acoustic_tensor_inverse_unit.sv
// Self-checking testbench for acoustic_tensor_inverse_unit: stiffness loads, then wave points.
// Depends on atinv_pkg and the unit RTL; predicts inverses with wide arithmetic unless given.
// Directed table rows first, then random loads and points with random idling on both sides.
module tb_acoustic_tensor_inverse_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS   = 60;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [atinv_pkg::INDEX_BITS-1:0] idx;
    logic [8:0][31:0]                 g;
    logic                             sing;
  } tensor_out_t;

  typedef struct {
    logic                             kind;
    logic [atinv_pkg::COEF_IDX_W-1:0] ci;
    atinv_pkg::q32_t                  cv;
    atinv_pkg::q32_t                  wx;
    atinv_pkg::q32_t                  wy;
    atinv_pkg::q32_t                  wz;
    logic [atinv_pkg::INDEX_BITS-1:0] pi;
    bit                               typed;
    tensor_out_t                      res;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [atinv_pkg::COEF_IDX_W-1:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_wave_x = '0;
  logic signed [31:0] in_wave_y = '0;
  logic signed [31:0] in_wave_z = '0;
  logic [atinv_pkg::INDEX_BITS-1:0] in_point_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [atinv_pkg::INDEX_BITS-1:0] out_index;
  logic signed [31:0] out_g11, out_g12, out_g13, out_g21, out_g22, out_g23;
  logic signed [31:0] out_g31, out_g32, out_g33;
  logic out_singular;

  atinv_pkg::q32_t stiffness[atinv_pkg::NUM_COEF];
  tensor_out_t     pending_results[$];
  stim_t           dir_rows[$];
  int              mismatches = 0;
  int              cycles = 0;
  bit              calm = 1'b0;

  acoustic_tensor_inverse_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic atinv_pkg::q32_t sat32(wide_t v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic tensor_out_t invert_tensor(atinv_pkg::q32_t wx, atinv_pkg::q32_t wy,
                                                atinv_pkg::q32_t wz,
                                                logic [atinv_pkg::INDEX_BITS-1:0] pi);
    tensor_out_t t;
    wide_t n[3], av[3][3], adj[3][3], acc, cf, det, mn, md, q;
    n[0] = wx;
    n[1] = wy;
    n[2] = wz;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            cf = stiffness[27 * r + 9 * k + 3 * l + c];
            acc = acc + n[k] * n[l] * cf;
          end
        end
        av[r][c] = sat32((acc + (128'sd1 <<< 31)) >>> 32);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        adj[r][c] = av[(c+1)%3][(r+1)%3] * av[(c+2)%3][(r+2)%3]
                  - av[(c+1)%3][(r+2)%3] * av[(c+2)%3][(r+1)%3];
      end
    end
    det = 0;
    for (int c = 0; c < 3; c++) det = det + av[0][c] * adj[c][0];
    t.idx  = pi;
    t.sing = (det == 0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (det == 0) begin
          t.g[3*r+c] = sat32((adj[r][c] + (128'sd1 <<< 15)) >>> 16);
        end else begin
          mn = (adj[r][c] < 0) ? -adj[r][c] : adj[r][c];
          mn = mn <<< 32;
          md = (det < 0) ? -det : det;
          q = (2 * mn + md) / (2 * md);
          if ((adj[r][c] < 0) != (det < 0)) q = -q;
          t.g[3*r+c] = sat32(q);
        end
      end
    end
    return t;
  endfunction

  function automatic atinv_pkg::q32_t rand_q();
    atinv_pkg::q32_t v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 32'h60000) - 32'h30000;
      3: v = $urandom_range(0, 32'h8000) - 32'h4000;
      4: v = (32'h10000 << $urandom_range(0, 3)) * ($urandom_range(0, 1) ? 1 : -1);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic stim_t load_row(int ci, atinv_pkg::q32_t cv);
    stim_t s;
    s = '{kind: atinv_pkg::KIND_LOAD, ci: atinv_pkg::COEF_IDX_W'(ci), cv: cv,
          wx: $urandom(), wy: $urandom(), wz: $urandom(),
          pi: atinv_pkg::INDEX_BITS'($urandom()), typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic stim_t point_row(atinv_pkg::q32_t wx, atinv_pkg::q32_t wy,
                                      atinv_pkg::q32_t wz, int pi);
    stim_t s;
    s = '{kind: atinv_pkg::KIND_POINT, ci: atinv_pkg::COEF_IDX_W'($urandom()),
          cv: $urandom(), wx: wx, wy: wy, wz: wz, pi: atinv_pkg::INDEX_BITS'(pi),
          typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic stim_t typed_point(atinv_pkg::q32_t wx, atinv_pkg::q32_t wy,
                                        atinv_pkg::q32_t wz, int pi,
                                        atinv_pkg::q32_t diag, bit sing);
    stim_t s;
    s = point_row(wx, wy, wz, pi);
    s.typed = 1'b1;
    s.res = '0;
    s.res.idx = atinv_pkg::INDEX_BITS'(pi);
    s.res.sing = sing;
    s.res.g[0] = diag;
    s.res.g[4] = diag;
    s.res.g[8] = diag;
    return s;
  endfunction

  task automatic report_mismatch(string what, longint expv, longint gotv);
    $display("[%0t] %s: expected %0h, got %0h", $time, what, expv, gotv);
    mismatches++;
  endtask

  task automatic send_item(stim_t s);
    bit taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= s.kind;
    in_coef_index  <= s.ci;
    in_coef_value  <= s.cv;
    in_wave_x      <= s.wx;
    in_wave_y      <= s.wy;
    in_wave_z      <= s.wz;
    in_point_index <= s.pi;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (s.kind == atinv_pkg::KIND_LOAD) begin
      if (s.ci < atinv_pkg::NUM_COEF) stiffness[s.ci] = s.cv;
    end else begin
      pending_results.push_back(s.typed ? s.res : invert_tensor(s.wx, s.wy, s.wz, s.pi));
    end
  endtask

  // result side: random stall bursts, none once calm
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    tensor_out_t e;
    logic [8:0][31:0] got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_g33, out_g32, out_g31, out_g23, out_g22, out_g21, out_g13, out_g12, out_g11};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, index", 0, out_index);
      end else begin
        e = pending_results.pop_front();
        if (out_index !== e.idx) report_mismatch("out_index", e.idx, out_index);
        if (out_singular !== e.sing) report_mismatch("singular", e.sing, out_singular);
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== e.g[i]) begin
            report_mismatch($sformatf("g%0d%0d idx %0h", i / 3 + 1, i % 3 + 1, e.idx),
                            e.g[i], got[i]);
          end
        end
      end
    end
  end

  initial begin
    stim_t s;
    int waited;
    for (int i = 0; i < atinv_pkg::NUM_COEF; i++) stiffness[i] = '0;

    dir_rows.push_back(typed_point(32'h10000, 0, 0, 0, 0, 1'b1));
    dir_rows.push_back(load_row(127, 32'h7fffffff));
    dir_rows.push_back(load_row(81, 32'h80000000));
    dir_rows.push_back(typed_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h3ffff,
                                   0, 1'b1));
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) dir_rows.push_back(load_row(28 * i + 12 * k, 32'h10000));
    end
    dir_rows.push_back(typed_point(32'h10000, 0, 0, 1, 32'h10000, 1'b0));
    dir_rows.push_back(typed_point(0, 32'hffff0000, 0, 2, 32'h10000, 1'b0));
    dir_rows.push_back(typed_point(0, 0, 32'h20000, 3, 32'h4000, 1'b0));
    dir_rows.push_back(typed_point(0, 0, 0, 4, 0, 1'b1));
    dir_rows.push_back(point_row(32'h80000000, 32'h80000000, 32'h80000000, 5));
    dir_rows.push_back(point_row(32'h7fffffff, 1, 32'hffffffff, 6));
    dir_rows.push_back(load_row(0, 32'h80000000));
    dir_rows.push_back(point_row(32'h18000, 32'h8000, 32'hfffe0000, 7));
    dir_rows.push_back(load_row(80, 32'h7fffffff));
    dir_rows.push_back(point_row(32'h10000, 32'h10000, 32'h10000, 8));
    dir_rows.push_back(load_row(0, 32'h10000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < atinv_pkg::NUM_COEF; i++) send_item(load_row(i, 0));
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        s = load_row($urandom_range(0, 9) == 0 ? $urandom_range(81, 127)
                     : $urandom_range(0, atinv_pkg::NUM_COEF - 1), rand_q());
      end else begin
        s = point_row(rand_q(), rand_q(), rand_q(), $urandom());
      end
      send_item(s);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_results.size() != 0)
        report_mismatch("results never delivered", 0, pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
